// ===== rtl/indexed_list_store_core_defines.svh =====
// ----------------------------------------------------------------------------
// Indexed list store assertion macros
// Shared property forms for the checker of the indexed list store.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_CORE_DEFINES_SVH
`define INDEXED_LIST_STORE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define ILS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list store check failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define ILS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list store check failed");

`endif

// ===== rtl/ils_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed list store package
// Command and status codes and the result record shared by the modules.
// ----------------------------------------------------------------------------
package ils_pkg;

  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 7;

  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BEFORE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic              strobe;
    logic [WORD_W-1:0] word;
    logic              valid;
    logic [STAT_W-1:0] status;
  } ils_result_t;

endpackage

// ===== rtl/indexed_list_store_core.sv =====
// ----------------------------------------------------------------------------
// Indexed list store core
// An ordered list of up to CAPACITY words with read, insert and delete.
// ----------------------------------------------------------------------------
// A command is taken at a rising edge where start is high and busy is low.
// in_cmd selects read, insert at head, insert at tail, insert before
// in_position, or delete at in_position; in_word_in is the word to insert.
// Every command gives one result, shown for a single cycle while out_strobe
// is high: the word read with its valid flag, a status code and the list
// length after the command. The receiver cannot hold results off.
// Commands that complete without moving data (rejects, appends, deleting the
// last item, unused codes) strobe the cycle after acceptance; a read strobes
// once the registered memory read data has passed through the result register.
// Inserting before position p moves count-p words, one per cycle through the
// single memory write port, then writes the new word at p and strobes.
// Deleting at position p moves count-p-1 words and then strobes.
// busy drops in the cycle the result is strobed, so a new command may be
// taken then. Reset empties the list; memory contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_store_core
  import ils_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [WORD_W-1:0] in_word_in,
  output logic                     out_strobe,
  output logic signed [WORD_W-1:0] out_word_out,
  output logic                     out_word_valid,
  output logic [STAT_W-1:0]        out_status,
  output logic [LEN_W-1:0]         out_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  ils_result_t       result;
  logic [CW-1:0]     count;
  logic [CW+LEN_W-1:0] count_ext;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  ils_seq #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cmd      (in_cmd),
    .position (in_position),
    .word_in  ($unsigned(in_word_in)),
    .busy     (busy),
    .result   (result),
    .count    (count),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ils_mem #(
    .DEPTH(CAPACITY)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // The length port carries the count modulo 128.
  assign count_ext      = (CW + LEN_W)'(count);
  assign out_length     = count_ext[LEN_W-1:0];
  assign out_strobe     = result.strobe;
  assign out_word_out   = $signed(result.word);
  assign out_word_valid = result.valid;
  assign out_status     = result.status;

endmodule

// ===== rtl/ils_mem.sv =====
// ----------------------------------------------------------------------------
// Indexed list store word memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module ils_mem
  import ils_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WORD_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WORD_W-1:0]        rdata
);

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/ils_seq.sv =====
// ----------------------------------------------------------------------------
// Indexed list store sequencer
// Decodes commands, walks the memory to shift entries and builds results.
// ----------------------------------------------------------------------------
module ils_seq
  import ils_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [CMD_W-1:0]            cmd,
  input  logic [POS_W-1:0]            position,
  input  logic [WORD_W-1:0]           word_in,
  output logic                        busy,
  output ils_result_t                 result,
  output logic [$clog2(CAPACITY+1)-1:0] count,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [WORD_W-1:0]           mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  logic [WORD_W-1:0]           mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_UP   = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_DN   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  ils_result_t       res_r, res_nxt;
  logic [AW-1:0]     wi_r, wi_nxt;
  logic [AW-1:0]     p_r, p_nxt;
  logic [WORD_W-1:0] w_r, w_nxt;

  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] ins_ext;
  logic          full;

  assign pos_ext = PW'(position);
  assign cnt_ext = PW'(count_r);
  assign full    = (count_r == CW'(CAPACITY));

  always_comb begin
    priority if (cmd == CMD_HEAD) begin
      ins_ext = '0;
    end else if (cmd == CMD_TAIL) begin
      ins_ext = cnt_ext;
    end else begin
      ins_ext = pos_ext;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    wi_nxt    = wi_r;
    p_nxt     = p_r;
    w_nxt     = w_r;

    res_nxt        = '0;
    res_nxt.status = ST_DONE;

    mem_we    = 1'b0;
    mem_waddr = wi_r;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          w_nxt = word_in;
          unique case (cmd)
            CMD_READ: begin
              if (pos_ext < cnt_ext) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(position);
                state_nxt = S_RD;
              end else begin
                res_nxt.strobe = 1'b1;
                res_nxt.status = ST_RANGE;
              end
            end
            CMD_HEAD, CMD_TAIL, CMD_BEFORE: begin
              if ((cmd == CMD_BEFORE) && (pos_ext > cnt_ext)) begin
                res_nxt.strobe = 1'b1;
                res_nxt.status = ST_RANGE;
              end else if (full) begin
                res_nxt.strobe = 1'b1;
                res_nxt.status = ST_FULL;
              end else if (ins_ext == cnt_ext) begin
                // Appending needs no shift: write straight past the last item.
                mem_we         = 1'b1;
                mem_waddr      = AW'(count_r);
                mem_wdata      = word_in;
                count_nxt      = count_r + CW'(1);
                res_nxt.strobe = 1'b1;
              end else begin
                // Walk downward from the end, moving each word up one slot.
                mem_re    = 1'b1;
                mem_raddr = AW'(count_r - CW'(1));
                wi_nxt    = AW'(count_r);
                p_nxt     = AW'(ins_ext);
                state_nxt = S_UP;
              end
            end
            CMD_DELETE: begin
              if (!(pos_ext < cnt_ext)) begin
                res_nxt.strobe = 1'b1;
                res_nxt.status = ST_RANGE;
              end else if ((pos_ext + PW'(1)) == cnt_ext) begin
                count_nxt      = count_r - CW'(1);
                res_nxt.strobe = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(position) + AW'(1);
                wi_nxt    = AW'(position);
                state_nxt = S_DN;
              end
            end
            default: begin
              res_nxt.strobe = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        res_nxt.strobe = 1'b1;
        res_nxt.word   = mem_rdata;
        res_nxt.valid  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_UP: begin
        // The word read last cycle from slot wi-1 lands in slot wi.
        mem_we = 1'b1;
        if ((wi_r - AW'(1)) == p_r) begin
          state_nxt = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = wi_r - AW'(2);
          wi_nxt    = wi_r - AW'(1);
        end
      end
      S_FIN: begin
        mem_we         = 1'b1;
        mem_waddr      = p_r;
        mem_wdata      = w_r;
        count_nxt      = count_r + CW'(1);
        res_nxt.strobe = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_DN: begin
        // The word read last cycle from slot wi+1 lands in slot wi.
        mem_we = 1'b1;
        if ((CW'(wi_r) + CW'(2)) == count_r) begin
          count_nxt      = count_r - CW'(1);
          res_nxt.strobe = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = wi_r + AW'(2);
          wi_nxt    = wi_r + AW'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      res_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      res_r      <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wi_r <= wi_nxt;
    p_r  <= p_nxt;
    w_r  <= w_nxt;
  end

  assign busy   = (state_r != S_IDLE);
  assign result = res_r;
  assign count  = count_r;

endmodule

// ===== rtl/ils_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed list store checker
// Port-level properties of the list store, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_list_store_core_defines.svh"

module ils_checker
  import ils_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_strobe,
  input logic signed [WORD_W-1:0] out_word_out,
  input logic                     out_word_valid,
  input logic [STAT_W-1:0]        out_status,
  input logic [LEN_W-1:0]         out_length
);

  // An accepted item either completes at once or keeps the block busy.
  `ILS_ASSERT_NEXT(a_accept_progress, clk, rst_n, start && !busy, busy || out_strobe)

  // A valid read word only comes with a done status.
  `ILS_ASSERT_NOW(a_valid_done, clk, rst_n, out_strobe && out_word_valid, out_status == ST_DONE)

  // Without a valid flag the word reads as zero.
  `ILS_ASSERT_NOW(a_invalid_zero, clk, rst_n, out_strobe && !out_word_valid, out_word_out == '0)

  // A rejected item leaves the length as it was.
  `ILS_ASSERT_NOW(a_reject_len, clk, rst_n, out_strobe && (out_status != ST_DONE),
                  $stable(out_length))

endmodule

bind indexed_list_store_core ils_checker u_ils_checker (.*);

// ===== tb/sv/indexed_list_store_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list store checker
// Watches the command and result ports of the list store. It keeps its own
// copy of the list, works out the result of every accepted item and compares
// each strobed result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module indexed_list_store_checker
  import ils_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     busy,
  input  logic [CMD_W-1:0]         in_cmd,
  input  logic [POS_W-1:0]         in_position,
  input  logic signed [WORD_W-1:0] in_word_in,
  input  logic                     out_strobe,
  input  logic signed [WORD_W-1:0] out_word_out,
  input  logic                     out_word_valid,
  input  logic [STAT_W-1:0]        out_status,
  input  logic [LEN_W-1:0]         out_length,
  output int                       fail_count,
  output int                       pending,
  output int                       checked_count,
  output int                       hit_count,
  output int                       range_count,
  output int                       full_count,
  output int                       peak_length
);

  typedef struct packed {
    logic signed [WORD_W-1:0] word;
    logic                     valid;
    logic [STAT_W-1:0]        status;
    logic [LEN_W-1:0]         length;
  } list_reply_t;

  logic signed [WORD_W-1:0] list_words [CAPACITY];
  int unsigned              list_len;
  list_reply_t              replies_due [$];

  function automatic void insert_word(int unsigned at, logic signed [WORD_W-1:0] w);
    int unsigned i;
    for (i = list_len; i > at; i--) list_words[i] = list_words[i-1];
    list_words[at] = w;
    list_len++;
  endfunction

  function automatic void remove_word(int unsigned at);
    int unsigned i;
    for (i = at; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
    list_len--;
  endfunction

  // Applies one command to the shadow list and returns the reply it must give.
  function automatic list_reply_t run_command(logic [CMD_W-1:0] cmd,
                                              logic [POS_W-1:0] pos,
                                              logic signed [WORD_W-1:0] w);
    list_reply_t r;
    logic        full;
    r        = '0;
    r.status = ST_DONE;
    full     = (list_len >= CAPACITY);
    case (cmd)
      CMD_READ: begin
        if (pos < list_len) begin
          r.word  = list_words[pos];
          r.valid = 1'b1;
        end else begin
          r.status = ST_RANGE;
        end
      end
      CMD_HEAD: begin
        if (full) r.status = ST_FULL;
        else insert_word(0, w);
      end
      CMD_TAIL: begin
        if (full) r.status = ST_FULL;
        else insert_word(list_len, w);
      end
      CMD_BEFORE: begin
        // The position check wins over the full check.
        if (pos > list_len) r.status = ST_RANGE;
        else if (full) r.status = ST_FULL;
        else insert_word(pos, w);
      end
      CMD_DELETE: begin
        if (pos < list_len) remove_word(pos);
        else r.status = ST_RANGE;
      end
      default: begin
      end
    endcase
    r.length = list_len[LEN_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [WORD_W-1:0] want,
                                      logic [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : watch
    list_reply_t want;
    if (!rst_n) begin
      list_len = 0;
      replies_due.delete();
    end else begin
      // The result of the previous item may strobe on the edge that takes
      // the next one, so results are handled before new items.
      if (out_strobe) begin
        if (replies_due.size() == 0) begin
          $error("result strobed with no item outstanding");
          fail_count++;
        end else begin
          want = replies_due.pop_front();
          check_field("word_out", want.word, out_word_out);
          check_field("word_valid", WORD_W'(want.valid), WORD_W'(out_word_valid));
          check_field("status", WORD_W'(want.status), WORD_W'(out_status));
          check_field("length", WORD_W'(want.length), WORD_W'(out_length));
          checked_count++;
          if (want.valid) hit_count++;
          if (want.status == ST_RANGE) range_count++;
          if (want.status == ST_FULL) full_count++;
        end
      end
      if (start && !busy) begin
        replies_due.push_back(run_command(in_cmd, in_position, in_word_in));
        if (int'(list_len) > peak_length) peak_length = list_len;
      end
    end
    pending = replies_due.size();
  end

endmodule

// ===== tb/sv/indexed_list_store_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed list store testbench
// Drives read, insert and delete commands into the list store with random
// gaps: a short directed opening, then random phases that fill, mix and
// drain the list. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module indexed_list_store_core_tb;
  import ils_pkg::*;

  localparam int CAPACITY    = 64;
  localparam int ITEM_TARGET = 1350;

  // Codes above delete are unused and act as no operation.
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_DELETE + 3'd1;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  localparam logic [WORD_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX  = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_ONES = 32'hffff_ffff;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [CMD_W-1:0]         in_cmd;
  logic [POS_W-1:0]         in_position;
  logic signed [WORD_W-1:0] in_word_in;
  logic                     out_strobe;
  logic signed [WORD_W-1:0] out_word_out;
  logic                     out_word_valid;
  logic [STAT_W-1:0]        out_status;
  logic [LEN_W-1:0]         out_length;

  int fail_count, pending, checked_count, hit_count, range_count, full_count;
  int peak_length;
  int issued;
  int seen_len;
  bit start_dropped;

  indexed_list_store_core #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_position   (in_position),
    .in_word_in    (in_word_in),
    .out_strobe    (out_strobe),
    .out_word_out  (out_word_out),
    .out_word_valid(out_word_valid),
    .out_status    (out_status),
    .out_length    (out_length)
  );

  indexed_list_store_checker #(
    .CAPACITY(CAPACITY)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_cmd        (in_cmd),
    .in_position   (in_position),
    .in_word_in    (in_word_in),
    .out_strobe    (out_strobe),
    .out_word_out  (out_word_out),
    .out_word_valid(out_word_valid),
    .out_status    (out_status),
    .out_length    (out_length),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .hit_count     (hit_count),
    .range_count   (range_count),
    .full_count    (full_count),
    .peak_length   (peak_length)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The list length as last reported steers position choices; it may lag
  // by one item, which only shifts the bias slightly.
  always @(posedge clk) begin
    if (!rst_n) seen_len <= 0;
    else if (out_strobe) seen_len <= int'(out_length);
  end

  // Holds start high until the block takes the item; start is left high so
  // that a back-to-back item needs no second assignment in the same step.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
                              logic [WORD_W-1:0] w);
    start       <= 1'b1;
    in_cmd      <= cmd;
    in_position <= pos;
    in_word_in  <= w;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  task automatic idle_gap(bit allow_gaps);
    int r;
    int gap;
    r   = $urandom_range(0, 99);
    gap = 0;
    if (allow_gaps) begin
      if (r >= 90) gap = $urandom_range(8, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    start_dropped = (gap > 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [POS_W-1:0] pick_position(int len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && len > 0) return POS_W'($urandom_range(0, len - 1));
    if (r < 80) return POS_W'(len);
    if (r < 85) return POS_W'(len + 1);
    return POS_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 19))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return WORD_ONES;
      default: return $urandom;
    endcase
  endfunction

  // Timeout guard.
  initial begin
    #10_000_000;
    $display("indexed_list_store_core verification failed");
    $finish;
  end

  initial begin
    int directed;
    int seg_len;
    int fill_pct;
    int r;
    int phase;
    bit gaps_on;
    logic [CMD_W-1:0] cmd;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_cmd      = CMD_READ;
    in_position = '0;
    in_word_in  = '0;
    issued      = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty-list rejects, then building a short list with extreme words.
    send_command(CMD_READ, 8'd0, '0);           idle_gap(1'b1);
    send_command(CMD_DELETE, 8'd0, '0);         idle_gap(1'b1);
    send_command(CMD_BEFORE, 8'd1, WORD_ONES);  idle_gap(1'b1);
    send_command(CMD_BEFORE, 8'd0, WORD_MAX);   idle_gap(1'b1);
    send_command(CMD_HEAD, 8'd255, WORD_MIN);   idle_gap(1'b1);
    send_command(CMD_TAIL, 8'd0, WORD_ONES);    idle_gap(1'b1);
    send_command(CMD_TAIL, 8'd255, '0);         idle_gap(1'b1);
    for (int p = 0; p < 4; p++) begin
      send_command(CMD_READ, POS_W'(p), '0);
      idle_gap(1'b1);
    end
    send_command(CMD_READ, 8'd4, '0);           idle_gap(1'b1);
    send_command(CMD_READ, 8'd255, WORD_ONES);  idle_gap(1'b1);
    // Insert in the middle, append at the length, reject past the length.
    send_command(CMD_BEFORE, 8'd2, 32'h1234_5678); idle_gap(1'b1);
    send_command(CMD_BEFORE, 8'd5, 32'ha5a5_a5a5); idle_gap(1'b1);
    send_command(CMD_BEFORE, 8'd7, 32'h5a5a_5a5a); idle_gap(1'b1);
    // Delete the head, the last entry and a middle one, then out of range.
    send_command(CMD_DELETE, 8'd0, '0);         idle_gap(1'b1);
    send_command(CMD_DELETE, 8'd4, '0);         idle_gap(1'b1);
    send_command(CMD_DELETE, 8'd1, '0);         idle_gap(1'b1);
    send_command(CMD_DELETE, 8'd3, '0);         idle_gap(1'b1);
    send_command(CMD_DELETE, 8'd255, '0);       idle_gap(1'b1);
    send_command(CMD_SPARE_FIRST, 8'd0, WORD_ONES);          idle_gap(1'b1);
    send_command(CMD_SPARE_FIRST + 3'd1, 8'd255, WORD_MIN);  idle_gap(1'b1);
    send_command(CMD_SPARE_LAST, 8'd1, WORD_MAX);            idle_gap(1'b1);
    send_command(CMD_READ, 8'd0, '0);           idle_gap(1'b1);
    send_command(CMD_READ, 8'd2, '0);           idle_gap(1'b1);
    directed = issued;

    // Random phases rotate between filling, mixing and draining so the list
    // regularly runs full and empty.
    phase = 0;
    while (issued < ITEM_TARGET) begin
      seg_len  = $urandom_range(80, 200);
      fill_pct = (phase % 3 == 0) ? 90 : (phase % 3 == 1) ? 50 : 15;
      gaps_on  = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < seg_len && issued < ITEM_TARGET; k++) begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        end else if ($urandom_range(0, 99) < fill_pct) begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_HEAD;
            1: cmd = CMD_TAIL;
            default: cmd = CMD_BEFORE;
          endcase
        end else begin
          cmd = ($urandom_range(0, 9) < 4) ? CMD_READ : CMD_DELETE;
        end
        send_command(cmd, pick_position(seen_len), pick_word());
        idle_gap(gaps_on);
      end
      phase++;
    end
    // The last gap may already have lowered start in this step.
    if (!start_dropped) start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (CAPACITY + 8) @(posedge clk);

    $display("Ran %0d commands (%0d directed) and checked %0d results.",
             issued, directed, checked_count);
    $display("Reads hit %0d, range rejects %0d, full rejects %0d, peak length %0d.",
             hit_count, range_count, full_count, peak_length);
    if (fail_count == 0 && pending == 0) begin
      $display("indexed_list_store_core verification clean");
    end else begin
      $display("indexed_list_store_core verification failed");
    end
    $finish;
  end

endmodule
